// ----- sv/wrapping_bitmap_byte_access_assert.svh -----
// Assertion helpers used by the bitmap access datapath.
`ifndef WRAPPING_BITMAP_BYTE_ACCESS_ASSERT_SVH
`define WRAPPING_BITMAP_BYTE_ACCESS_ASSERT_SVH

// Clocked property, disabled while the active-low reset is asserted.
`define WBA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge.
`define WBA_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `WBA_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

// ----- sv/wba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wba_pkg;

    // Field widths of the transaction payloads
    localparam int OP_W      = 2;
    localparam int ROW_W     = 5;
    localparam int COL_W     = 6;
    localparam int BYTE_W    = 8;
    localparam int BIT_SEL_W = 3;

    // Pixels covered by one byte access
    localparam int PIX_PER_BYTE = 8;

    // Default bitmap geometry
    localparam int DEF_ROW_PIXELS = 64;
    localparam int DEF_ROW_COUNT  = 32;

    typedef enum logic [OP_W-1:0] {
        OP_RD_PIX  = 2'd0,
        OP_WR_PIX  = 2'd1,
        OP_RD_BYTE = 2'd2,
        OP_WR_BYTE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_FINISH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic clr_step;
        logic modify;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic last_byte;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- sv/wba_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface wba_in_if
    import wba_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              pixel_value;
    logic [BYTE_W-1:0] byte_value;

    modport source (
        output valid, op, row, col, pixel_value, byte_value,
        input  ready
    );

    modport sink (
        input  valid, op, row, col, pixel_value, byte_value,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/wba_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface wba_out_if
    import wba_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;

    modport source (
        output valid, read_data,
        input  ready
    );

    modport sink (
        input  valid, read_data,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/wba_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/wba_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wba_ctrl
    import wba_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register; reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_MODIFY;
            end
            ST_MODIFY: begin
                priority if (!i_sts.last_byte) n_state = ST_READ;
                else if (i_sts.out_free)       n_state = ST_IDLE;
                else                           n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_READ: begin
                // address is presented by the datapath, nothing to command
            end
            ST_MODIFY: begin
                o_cmd.modify = 1'b1;
                o_cmd.finish = i_sts.last_byte & i_sts.out_free;
            end
            ST_FINISH: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/wba_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "wrapping_bitmap_byte_access_assert.svh"

module wba_dp
    import wba_pkg::*;
#(
    parameter int ROW_PIXELS = DEF_ROW_PIXELS,
    parameter int ROW_COUNT  = DEF_ROW_COUNT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [ROW_W-1:0]  i_row,
    input  wire logic [COL_W-1:0]  i_col,
    input  wire logic              i_pixel_value,
    input  wire logic [BYTE_W-1:0] i_byte_value,
    output logic                   o_out_valid,
    output logic      [BYTE_W-1:0] o_read_data,
    input  wire logic              i_out_ready
);

    localparam int PIX_TOTAL   = ROW_PIXELS * ROW_COUNT;
    localparam int STORE_BYTES = (PIX_TOTAL + BYTE_W - 1) / BYTE_W;
    localparam int IW          = $clog2(PIX_TOTAL);
    localparam int AW          = IW - BIT_SEL_W;
    localparam int CW          = $clog2(ROW_PIXELS);
    localparam int RW          = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int ROW_CODES   = 2 ** ROW_W;
    localparam int COL_CODES   = 2 ** COL_W;

    // Wrap tables for out-of-range row and column fields
    logic [RW-1:0] w_row_tbl [ROW_CODES];
    logic [CW-1:0] w_col_tbl [COL_CODES];

    for (genvar g = 0; g < ROW_CODES; g++) begin : g_row_tbl
        assign w_row_tbl[g] = RW'(g % ROW_COUNT);
    end
    for (genvar g = 0; g < COL_CODES; g++) begin : g_col_tbl
        assign w_col_tbl[g] = CW'(g % ROW_PIXELS);
    end

    t_op                   r_op;
    logic [IW-1:0]         r_base;
    logic [CW-1:0]         r_col;
    logic [BYTE_W-1:0]     r_wval;
    logic [PIX_PER_BYTE-1:0] r_done;
    logic [PIX_PER_BYTE-1:0] n_done;
    logic [BYTE_W-1:0]     r_res;
    logic [BYTE_W-1:0]     n_res;
    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_read_data;
    logic [AW-1:0]         r_clr_addr;

    logic [IW-1:0]           w_pix_idx [PIX_PER_BYTE];
    logic [AW-1:0]           w_addr;
    logic [PIX_PER_BYTE-1:0] w_active;
    logic [BYTE_W-1:0]       w_rdata;
    logic [BYTE_W-1:0]       w_mask;
    logic [BYTE_W-1:0]       w_bits;
    logic [BYTE_W-1:0]       w_gath;
    logic [BYTE_W-1:0]       w_wdata;
    logic                    w_is_write;
    logic                    w_ram_we;

    // Latch the access: row start offset, wrapped column, write pixels
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_op);
            r_base <= IW'(w_row_tbl[i_row]) * IW'(ROW_PIXELS);
            r_col  <= w_col_tbl[i_col];
            r_wval <= (t_op'(i_op) == OP_WR_PIX) ? {i_pixel_value, (BYTE_W-1)'(0)}
                                                  : i_byte_value;
        end
    end

    // Bit index of each pixel of the access, wrapping inside the row
    for (genvar k = 0; k < PIX_PER_BYTE; k++) begin : g_idx
        logic [CW:0] w_sum;
        assign w_sum = {1'b0, r_col} + (CW+1)'(k);
        assign w_pix_idx[k] = r_base + IW'((w_sum >= (CW+1)'(ROW_PIXELS)) ?
                                           w_sum - (CW+1)'(ROW_PIXELS) : w_sum);
    end

    // Byte holding the lowest pending pixel
    always_comb begin
        w_addr = w_pix_idx[PIX_PER_BYTE-1][IW-1:BIT_SEL_W];
        for (int k = PIX_PER_BYTE - 1; k >= 0; k--) begin
            if (!r_done[k]) w_addr = w_pix_idx[k][IW-1:BIT_SEL_W];
        end
    end

    // Pending pixels that live in that byte
    always_comb begin
        for (int k = 0; k < PIX_PER_BYTE; k++) begin
            w_active[k] = !r_done[k] && (w_pix_idx[k][IW-1:BIT_SEL_W] == w_addr);
        end
    end

    // Merge: gather read bits, build write mask (MSB-first inside a byte)
    always_comb begin
        w_mask = '0;
        w_bits = '0;
        w_gath = '0;
        for (int k = 0; k < PIX_PER_BYTE; k++) begin
            if (w_active[k]) begin
                w_mask[~w_pix_idx[k][BIT_SEL_W-1:0]] = 1'b1;
                w_bits[~w_pix_idx[k][BIT_SEL_W-1:0]] = r_wval[PIX_PER_BYTE-1-k];
                w_gath[PIX_PER_BYTE-1-k] = w_rdata[~w_pix_idx[k][BIT_SEL_W-1:0]];
            end
        end
    end

    assign w_wdata    = (w_rdata & ~w_mask) | (w_bits & w_mask);
    assign w_is_write = (r_op == OP_WR_PIX) || (r_op == OP_WR_BYTE);
    assign w_ram_we   = i_cmd.clr_step | (i_cmd.modify & w_is_write);

    // Frame store
    wba_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (i_cmd.clr_step ? r_clr_addr : w_addr),
        .i_wdata (i_cmd.clr_step ? '0 : w_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // Pixel progress and gathered read bits
    always_comb begin
        n_done = r_done;
        n_res  = r_res;
        if (i_cmd.load) begin
            n_done = (t_op'(i_op) == OP_RD_PIX || t_op'(i_op) == OP_WR_PIX) ?
                     {{(PIX_PER_BYTE-1){1'b1}}, 1'b0} : '0;
            n_res  = '0;
        end else if (i_cmd.modify) begin
            n_done = r_done | w_active;
            n_res  = r_res | w_gath;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '1;
            r_out_valid <= 1'b0;
            r_clr_addr  <= '0;
        end else begin
            r_done <= n_done;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (i_cmd.finish) begin
            unique case (r_op)
                OP_RD_PIX:  r_read_data <= {(BYTE_W-1)'(0), n_res[BYTE_W-1]};
                OP_RD_BYTE: r_read_data <= n_res;
                OP_WR_PIX,
                OP_WR_BYTE: r_read_data <= '0;
            endcase
        end
    end

    assign o_sts.clr_last  = (r_clr_addr == AW'(STORE_BYTES - 1));
    assign o_sts.last_byte = ((r_done | w_active) == '1);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_read_data;

    // A new access always leaves at least one pixel pending
    `WBA_ASSERT(a_load_pending, i_clk, i_rst_n, i_cmd.load |=> (r_done != '1), "load left no pixel pending")
    // Every merge cycle handles at least one pixel
    `WBA_ASSERT_NEVER(a_modify_empty, i_clk, i_rst_n, i_cmd.modify && (w_active == '0), "merge with no pixel")
    // A finished result never overwrites one still waiting
    `WBA_ASSERT(a_finish_free, i_clk, i_rst_n, i_cmd.finish |-> (!r_out_valid || i_out_ready), "result overwritten")

endmodule

`default_nettype wire

// ----- sv/wrapping_bitmap_byte_access.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Packed monochrome bitmap (ROW_COUNT rows of ROW_PIXELS pixels, MSB = leftmost)
// with pixel and eight-pixel access. Byte accesses wrap back to column 0 of
// the same row.
// i_in: op, row, col, pixel_value, byte_value; one transaction per access.
// o_out: read_data, one transaction per accepted access, in order.
// For each touched frame-store byte the sequencer passes a read state and a
// merge/write state on the single-port-write RAM, after the idle/accept state.
// When the output register is free, the result is registered and o_out.valid
// raised as the last byte's merge ends. A byte access touches 1 or 2 bytes when
// ROW_PIXELS is a multiple of 8, up to 4 otherwise. The next transaction can be
// taken in the idle state entered as the result is registered.
// Reset: a sweep writes zero to every one of the (ROW_PIXELS*ROW_COUNT+7)/8
// frame-store bytes (256 by default), one byte per cycle; i_in is not ready then.
// Receiver stall: the result waits in the output register; one more transaction
// is still accepted and processed, then held finished, and no further
// transaction is taken until the waiting result leaves.

module wrapping_bitmap_byte_access
    import wba_pkg::*;
#(
    parameter int ROW_PIXELS = DEF_ROW_PIXELS,
    parameter int ROW_COUNT  = DEF_ROW_COUNT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wba_in_if.sink    i_in,
    wba_out_if.source o_out
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    // Sequencer
    wba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Frame store and access datapath
    wba_dp #(
        .ROW_PIXELS (ROW_PIXELS),
        .ROW_COUNT  (ROW_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_op          (i_in.op),
        .i_row         (i_in.row),
        .i_col         (i_in.col),
        .i_pixel_value (i_in.pixel_value),
        .i_byte_value  (i_in.byte_value),
        .o_out_valid   (o_out.valid),
        .o_read_data   (o_out.read_data),
        .i_out_ready   (o_out.ready)
    );

    assign i_in.ready = w_in_ready;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import wba_pkg::*;

    localparam int NUM_RANDOM  = 1530;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 40;
    localparam int MAX_REPORTS = 10;
    localparam int BITMAP_BITS = DEF_ROW_COUNT * DEF_ROW_PIXELS;

    // One bitmap access as driven on i_in, plus an optional hand-typed result
    typedef struct packed {
        t_op               op;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              pixel_value;
        logic [BYTE_W-1:0] byte_value;
        logic              typed;
        logic [BYTE_W-1:0] typed_data;
    } t_access;

    logic i_clk;
    logic i_rst_n;

    wba_in_if  in_if ();
    wba_out_if out_if ();

    wrapping_bitmap_byte_access i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Shadow bitmap, one entry per pixel, row-major
    logic              pixels [BITMAP_BITS] = '{default: 1'b0};
    logic [BYTE_W-1:0] awaited_data [$];
    t_access           cur_access;
    int                mismatches = 0;
    int                cycles = 0;
    logic              calm = 1'b0;

    // Directed accesses: row/column extremes, wrap at the row end, ignored fields
    t_access dir_tab [21] = '{
        '{OP_RD_PIX,  5'd0,  6'd0,  1'b0, 8'h00, 1'b1, 8'h00},
        '{OP_RD_BYTE, 5'd31, 6'd63, 1'b1, 8'hFF, 1'b1, 8'h00},
        '{OP_RD_BYTE, 5'd0,  6'd0,  1'b0, 8'h00, 1'b1, 8'h00},
        '{OP_WR_PIX,  5'd0,  6'd0,  1'b1, 8'hFF, 1'b1, 8'h00},
        '{OP_RD_PIX,  5'd0,  6'd0,  1'b0, 8'h00, 1'b1, 8'h01},
        '{OP_RD_BYTE, 5'd0,  6'd0,  1'b0, 8'h00, 1'b1, 8'h80},
        '{OP_WR_BYTE, 5'd31, 6'd60, 1'b0, 8'hA5, 1'b1, 8'h00},
        '{OP_RD_BYTE, 5'd31, 6'd60, 1'b0, 8'h00, 1'b1, 8'hA5},
        '{OP_RD_BYTE, 5'd31, 6'd0,  1'b0, 8'h00, 1'b0, 8'h00},
        '{OP_RD_PIX,  5'd31, 6'd63, 1'b0, 8'h00, 1'b0, 8'h00},
        '{OP_WR_BYTE, 5'd31, 6'd57, 1'b1, 8'hFF, 1'b1, 8'h00},
        '{OP_RD_BYTE, 5'd31, 6'd56, 1'b0, 8'h00, 1'b0, 8'h00},
        '{OP_WR_PIX,  5'd0,  6'd0,  1'b0, 8'hFF, 1'b1, 8'h00},
        '{OP_WR_BYTE, 5'd5,  6'd8,  1'b1, 8'h00, 1'b1, 8'h00},
        '{OP_RD_BYTE, 5'd0,  6'd63, 1'b1, 8'hFF, 1'b0, 8'h00},
        '{OP_WR_BYTE, 5'd15, 6'd32, 1'b0, 8'hFF, 1'b1, 8'h00},
        '{OP_RD_BYTE, 5'd15, 6'd32, 1'b0, 8'h00, 1'b1, 8'hFF},
        '{OP_RD_BYTE, 5'd15, 6'd28, 1'b0, 8'h00, 1'b0, 8'h00},
        '{OP_RD_PIX,  5'd15, 6'd39, 1'b0, 8'h00, 1'b1, 8'h01},
        '{OP_WR_PIX,  5'd31, 6'd63, 1'b0, 8'h00, 1'b1, 8'h00},
        '{OP_RD_BYTE, 5'd31, 6'd63, 1'b0, 8'h00, 1'b0, 8'h00}
    };

    // Clock and reset
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Apply one access to the shadow bitmap; returns the read data it yields
    function automatic logic [BYTE_W-1:0] apply_access(t_access a);
        logic [BYTE_W-1:0] rd;
        int                base;
        int                cc;
        rd   = '0;
        base = int'(a.row) * DEF_ROW_PIXELS;
        case (a.op)
            OP_RD_PIX: rd[0] = pixels[base + int'(a.col)];
            OP_WR_PIX: pixels[base + int'(a.col)] = a.pixel_value;
            OP_RD_BYTE: begin
                for (int i = 0; i < PIX_PER_BYTE; i++) begin
                    cc = (int'(a.col) + i) % DEF_ROW_PIXELS;
                    rd[PIX_PER_BYTE-1-i] = pixels[base + cc];
                end
            end
            default: begin
                for (int i = 0; i < PIX_PER_BYTE; i++) begin
                    cc = (int'(a.col) + i) % DEF_ROW_PIXELS;
                    pixels[base + cc] = a.byte_value[PIX_PER_BYTE-1-i];
                end
            end
        endcase
        return rd;
    endfunction

    // Random access: hot rows and row-end columns get extra weight
    function automatic t_access random_access();
        t_access a;
        int      hot [4] = '{0, 7, 30, 31};
        a.op          = t_op'($urandom_range(0, 3));
        a.row         = ($urandom_range(0, 9) < 6) ? ROW_W'(hot[$urandom_range(0, 3)])
                                                   : ROW_W'($urandom_range(0, 31));
        a.col         = ($urandom_range(0, 9) < 4) ? COL_W'($urandom_range(56, 63))
                                                   : COL_W'($urandom_range(0, 63));
        a.pixel_value = 1'($urandom_range(0, 1));
        a.byte_value  = BYTE_W'($urandom_range(0, 255));
        a.typed       = 1'b0;
        a.typed_data  = '0;
        return a;
    endfunction

    // Idle length: mostly short, now and then long, none while calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report(string what, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s, expected %02h, got %02h",
                     cycles, what, want, got);
    endtask

    // Drive one transaction on i_in and hold it until accepted
    task automatic drive_access(t_access a);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cur_access        <= a;
        in_if.valid       <= 1'b1;
        in_if.op          <= a.op;
        in_if.row         <= a.row;
        in_if.col         <= a.col;
        in_if.pixel_value <= a.pixel_value;
        in_if.byte_value  <= a.byte_value;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
    endtask

    // Receiver: random back-pressure on o_out
    initial begin : rx_stall
        int stall_left;
        stall_left   = 0;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // Cycle limit and calm stretches
    always @(posedge i_clk) begin
        cycles++;
        if (cycles % 300 == 0) calm <= ($urandom_range(0, 3) == 0);
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Scoreboard: predict on accepted accesses, compare on accepted results
    always @(posedge i_clk) begin : scoreboard
        logic [BYTE_W-1:0] pred;
        logic [BYTE_W-1:0] want;
        if (in_if.valid && in_if.ready) begin
            pred = apply_access(cur_access);
            awaited_data.push_back(cur_access.typed ? cur_access.typed_data : pred);
        end
        if (out_if.valid && out_if.ready) begin
            if (awaited_data.size() == 0) begin
                report("result with no access pending", '0, out_if.read_data);
            end else begin
                want = awaited_data.pop_front();
                if (out_if.read_data !== want) report("read_data", want, out_if.read_data);
            end
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        in_if.valid       = 1'b0;
        in_if.op          = OP_RD_PIX;
        in_if.row         = '0;
        in_if.col         = '0;
        in_if.pixel_value = 1'b0;
        in_if.byte_value  = '0;
        cur_access        = '0;
        wait (i_rst_n === 1'b1);

        foreach (dir_tab[k]) drive_access(dir_tab[k]);
        for (int n = 0; n < NUM_RANDOM; n++) drive_access(random_access());

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (awaited_data.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (awaited_data.size() != 0) begin
            mismatches += awaited_data.size();
            $display("%0d results never arrived", awaited_data.size());
        end

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/wba_pkg.sv
sv/wba_in_if.sv
sv/wba_out_if.sv
sv/wba_ram.sv
sv/wba_ctrl.sv
sv/wba_dp.sv
sv/wrapping_bitmap_byte_access.sv
sim/tb.sv
